/* sv/evwd_pkg.sv */
// shared widths, reset values, register indexes and stage structs for the vad wake detector
package evwd_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int SQ_W       = 31;
  localparam int ENERGY_W   = 41;
  localparam int THR_W      = 31;
  localparam int RUN_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 31;

  localparam int MAX_FRAME_DEFAULT = 512;

  localparam logic [THR_W-1:0] THR_RESET      = THR_W'(8100);
  localparam logic [RUN_W-1:0] WAKE_RUN_RESET = RUN_W'(1920);
  localparam logic [RUN_W-1:0] RUN_MAX        = {RUN_W{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MEAN_SQ_THR = 2'd0,
    CFG_WAKE_RUN    = 2'd1
  } cfg_idx_e;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       frame_end;
    logic                       asleep;
  } in_item_t;

  typedef struct packed {
    logic [SQ_W-1:0] sq;
    logic            last;
    logic            asleep;
  } front_t;

  typedef struct packed {
    logic voiced;
    logic asleep;
  } energy_t;

  typedef struct packed {
    logic             frame_voiced;
    logic             wake;
    logic [RUN_W-1:0] voiced_run;
  } result_t;

endpackage

/* sv/evwd_if.sv */
// request channel interfaces: sample input, frame result output, register writes
interface evwd_in_if;
  import evwd_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       frame_end;
  logic                       asleep;

  modport source (output valid, output sample, output frame_end, output asleep, input ready);
  modport sink (input valid, input sample, input frame_end, input asleep, output ready);
endinterface

interface evwd_out_if;
  import evwd_pkg::*;
  logic             valid;
  logic             ready;
  logic             frame_voiced;
  logic             wake;
  logic [RUN_W-1:0] voiced_run;

  modport source (output valid, output frame_voiced, output wake, output voiced_run,
                  input ready);
  modport sink (input valid, input frame_voiced, input wake, input voiced_run,
                output ready);
endinterface

interface evwd_cfg_if;
  import evwd_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

/* sv/evwd_front.sv */
// input register, sample squaring and frame sample counting
module evwd_front #(
  parameter int MAX_FRAME = evwd_pkg::MAX_FRAME_DEFAULT,
  parameter int NW        = ((MAX_FRAME > 1) ? $clog2(MAX_FRAME) : 1) + 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  evwd_pkg::in_item_t in_item_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output evwd_pkg::front_t  out_item_o,
  output logic [NW-1:0]     out_n_o
);
  import evwd_pkg::*;

  localparam int CNTW = NW - 1;

  logic                       a_valid_q;
  in_item_t                   a_item_q;
  logic                       a_ready;
  logic                       b_valid_q;
  front_t                     b_item_q;
  logic [NW-1:0]              b_n_q;
  logic                       b_ready;
  logic [CNTW-1:0]            cnt_q;
  logic [CNTW-1:0]            cnt_d;
  logic signed [SAMPLE_W-1:0] smp;
  logic signed [2*SAMPLE_W-1:0] sq_full;
  logic [NW-1:0]              n;
  logic                       last;

  assign b_ready    = !b_valid_q || out_ready_i;
  assign a_ready    = !a_valid_q || b_ready;
  assign in_ready_o = a_ready;

  assign smp     = a_item_q.sample;
  assign sq_full = smp * smp;
  assign n       = {1'b0, cnt_q} + NW'(1);
  // a frame that fills up ends on its own
  assign last    = a_item_q.frame_end || (n >= NW'(MAX_FRAME));
  assign cnt_d   = last ? '0 : n[CNTW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      cnt_q     <= '0;
    end else begin
      if (a_ready) begin
        a_valid_q <= in_valid_i;
      end
      if (b_ready) begin
        b_valid_q <= a_valid_q;
        if (a_valid_q) begin
          cnt_q <= cnt_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_ready && in_valid_i) begin
      a_item_q <= in_item_i;
    end
    if (b_ready && a_valid_q) begin
      b_item_q.sq     <= sq_full[SQ_W-1:0];
      b_item_q.last   <= last;
      b_item_q.asleep <= a_item_q.asleep;
      b_n_q           <= n;
    end
  end

  assign out_valid_o = b_valid_q;
  assign out_item_o  = b_item_q;
  assign out_n_o     = b_n_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, cnt_q} < NW'(MAX_FRAME))
    else $error("frame sample count reached the frame limit");

endmodule

/* sv/evwd_energy.sv */
// frame energy accumulation, threshold product and voiced decision
module evwd_energy #(
  parameter int NW = 10
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  evwd_pkg::front_t         in_item_i,
  input  logic [NW-1:0]            in_n_i,
  input  logic [evwd_pkg::THR_W-1:0] thr_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output evwd_pkg::energy_t        out_item_o,
  output logic [NW-1:0]            out_n_o
);
  import evwd_pkg::*;

  localparam int PW = THR_W + NW;
  localparam int CW = (PW > ENERGY_W) ? PW : ENERGY_W;

  logic [ENERGY_W-1:0] acc_q;
  logic [ENERGY_W-1:0] total;
  logic [PW-1:0]       prod;
  logic                c_valid_q;
  logic                c_ready;
  logic [ENERGY_W-1:0] c_total_q;
  logic [PW-1:0]       c_prod_q;
  logic                c_asleep_q;
  logic [NW-1:0]       c_n_q;
  logic                d_valid_q;
  logic                d_ready;
  energy_t             d_item_q;
  logic [NW-1:0]       d_n_q;
  logic                voiced;

  assign d_ready    = !d_valid_q || out_ready_i;
  assign c_ready    = !c_valid_q || d_ready;
  assign in_ready_o = c_ready;

  assign total  = acc_q + ENERGY_W'(in_item_i.sq);
  assign prod   = PW'(thr_i) * PW'(in_n_i);
  assign voiced = CW'(c_total_q) >= CW'(c_prod_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q     <= '0;
      c_valid_q <= 1'b0;
      d_valid_q <= 1'b0;
    end else begin
      if (c_ready) begin
        // only frame ends move on; other samples just accumulate
        c_valid_q <= in_valid_i && in_item_i.last;
        if (in_valid_i) begin
          acc_q <= in_item_i.last ? '0 : total;
        end
      end
      if (d_ready) begin
        d_valid_q <= c_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (c_ready && in_valid_i && in_item_i.last) begin
      c_total_q  <= total;
      c_prod_q   <= prod;
      c_asleep_q <= in_item_i.asleep;
      c_n_q      <= in_n_i;
    end
    if (d_ready && c_valid_q) begin
      d_item_q.voiced <= voiced;
      d_item_q.asleep <= c_asleep_q;
      d_n_q           <= c_n_q;
    end
  end

  assign out_valid_o = d_valid_q;
  assign out_item_o  = d_item_q;
  assign out_n_o     = d_n_q;

endmodule

/* sv/evwd_run.sv */
// voiced run counter, wake decision and result register
module evwd_run #(
  parameter int NW = 10
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  evwd_pkg::energy_t          in_item_i,
  input  logic [NW-1:0]              in_n_i,
  input  logic [evwd_pkg::RUN_W-1:0] wake_run_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output evwd_pkg::result_t          out_item_o
);
  import evwd_pkg::*;

  localparam int SUMW = RUN_W + 1;

  logic             take;
  logic [RUN_W-1:0] cnt_q;
  logic [RUN_W-1:0] cnt_d;
  logic [SUMW-1:0]  sum;
  logic [RUN_W-1:0] sat;
  logic             grow;
  logic             wake;
  logic             o_valid_q;
  result_t          o_item_q;

  assign in_ready_o = !o_valid_q || out_ready_i;
  assign take       = in_valid_i && in_ready_o;

  assign sum   = {1'b0, cnt_q} + SUMW'(in_n_i);
  assign sat   = sum[SUMW-1] ? RUN_MAX : sum[RUN_W-1:0];
  assign grow  = in_item_i.asleep && in_item_i.voiced;
  assign wake  = grow && (sat >= wake_run_i);
  // awake, unvoiced or woken: the run starts over
  assign cnt_d = (grow && !wake) ? sat : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      o_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        o_valid_q <= in_valid_i;
      end
      if (take) begin
        cnt_q <= cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      o_item_q.frame_voiced <= in_item_i.voiced;
      o_item_q.wake         <= wake;
      o_item_q.voiced_run   <= cnt_d;
    end
  end

  assign out_valid_o = o_valid_q;
  assign out_item_o  = o_item_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    o_valid_q && o_item_q.wake |-> o_item_q.frame_voiced)
    else $error("wake on an unvoiced frame");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    o_valid_q && (o_item_q.wake || !o_item_q.frame_voiced) |-> o_item_q.voiced_run == '0)
    else $error("run not cleared after wake or unvoiced frame");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |=> cnt_q == o_item_q.voiced_run)
    else $error("reported run differs from held run");

endmodule

/* sv/energy_vad_wake_detector.sv */
// a frame's last sample passes registers a, b, c, d; its result is then registered
// throughput: one sample per cycle unless stalled; only frame ends give a result
// the only stall comes from the result register when the output request is not taken
// reset clears the energy sum, frame count and run, and loads threshold 8100, run 1920
// register writes are taken every cycle
module energy_vad_wake_detector #(
  parameter int MAX_FRAME = evwd_pkg::MAX_FRAME_DEFAULT
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  evwd_in_if.sink         in_i,
  evwd_out_if.source      out_o,
  evwd_cfg_if.sink        cfg_i
);
  import evwd_pkg::*;

  localparam int NW = ((MAX_FRAME > 1) ? $clog2(MAX_FRAME) : 1) + 1;

  logic [THR_W-1:0] thr_q;
  logic [RUN_W-1:0] wake_run_q;
  in_item_t         in_item;
  logic             f_valid;
  logic             f_ready;
  front_t           f_item;
  logic [NW-1:0]    f_n;
  logic             e_valid;
  logic             e_ready;
  energy_t          e_item;
  logic [NW-1:0]    e_n;
  result_t          res;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q      <= THR_RESET;
      wake_run_q <= WAKE_RUN_RESET;
    end else if (cfg_i.valid) begin
      case (cfg_idx_e'(cfg_i.index))
        CFG_MEAN_SQ_THR: thr_q      <= cfg_i.data[THR_W-1:0];
        CFG_WAKE_RUN:    wake_run_q <= cfg_i.data[RUN_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_item.sample    = in_i.sample;
  assign in_item.frame_end = in_i.frame_end;
  assign in_item.asleep    = in_i.asleep;

  evwd_front #(
    .MAX_FRAME (MAX_FRAME),
    .NW        (NW)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .in_item_i   (in_item),
    .out_valid_o (f_valid),
    .out_ready_i (f_ready),
    .out_item_o  (f_item),
    .out_n_o     (f_n)
  );

  evwd_energy #(
    .NW (NW)
  ) u_energy (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (f_valid),
    .in_ready_o  (f_ready),
    .in_item_i   (f_item),
    .in_n_i      (f_n),
    .thr_i       (thr_q),
    .out_valid_o (e_valid),
    .out_ready_i (e_ready),
    .out_item_o  (e_item),
    .out_n_o     (e_n)
  );

  evwd_run #(
    .NW (NW)
  ) u_run (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (e_valid),
    .in_ready_o  (e_ready),
    .in_item_i   (e_item),
    .in_n_i      (e_n),
    .wake_run_i  (wake_run_q),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_item_o  (res)
  );

  assign out_o.frame_voiced = res.frame_voiced;
  assign out_o.wake         = res.wake;
  assign out_o.voiced_run   = res.voiced_run;

endmodule
